// File: hdl/cbm_pkg.sv
// shared types, codes and reset values for the cartridge bank mapper
package cbm_pkg;

    localparam int ADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int ROM_W  = 7;
    localparam int RAM_W  = 2;
    localparam int NIB_W  = 4;
    localparam int TYPE_W = 2;

    localparam logic [TYPE_W-1:0] MAPPER_NONE = 2'd0;
    localparam logic [TYPE_W-1:0] MAPPER_MBC1 = 2'd1;
    localparam logic [TYPE_W-1:0] MAPPER_MBC2 = 2'd2;
    localparam logic [TYPE_W-1:0] MAPPER_MBC3 = 2'd3;

    // address bits 15:13 select the register window
    localparam logic [2:0] REGION_ENABLE = 3'd0;
    localparam logic [2:0] REGION_ROM    = 3'd1;
    localparam logic [2:0] REGION_UPPER  = 3'd2;
    localparam logic [2:0] REGION_MODE   = 3'd3;

    localparam logic [NIB_W-1:0] ENABLE_KEY = 4'hA;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_in_word;

    typedef struct packed {
        logic [ROM_W-1:0] rom_bank;
        logic [RAM_W-1:0] ram_bank;
        logic             ram_enabled;
        logic             rom_remapped;
        logic             ram_remapped;
        logic             enable_written;
        logic             write_ignored;
    } t_out_word;

    typedef struct packed {
        logic [NIB_W-1:0] enable_nibble;
        logic [ROM_W-1:0] rom_select;
        logic [RAM_W-1:0] upper_select;
        logic             banking_mode;
        logic [ROM_W-1:0] mapped_rom;
        logic [RAM_W-1:0] mapped_ram;
    } t_bank_state;

    localparam t_bank_state BANK_RESET = '{
        enable_nibble: 4'd0,
        rom_select:    7'd1,
        upper_select:  2'd0,
        banking_mode:  1'b0,
        mapped_rom:    7'd1,
        mapped_ram:    2'd0
    };

endpackage

// File: hdl/cbm_decode.sv
// write decode and next bank state for the selected controller
module cbm_decode (
    input  logic [cbm_pkg::TYPE_W-1:0] i_type,
    input  cbm_pkg::t_in_word          i_word,
    input  cbm_pkg::t_bank_state       i_state,
    output cbm_pkg::t_bank_state       o_state,
    output cbm_pkg::t_out_word         o_word
);

    logic [2:0]                 region;
    logic                       a8;
    logic [cbm_pkg::ROM_W-1:0]  sel5;
    logic [cbm_pkg::ROM_W-1:0]  sel4;
    logic [cbm_pkg::ROM_W-1:0]  sel7;
    logic [cbm_pkg::RAM_W-1:0]  upper;
    logic                       rom_re;
    logic                       ram_re;
    logic                       en_wr;
    logic                       ignored;

    assign region = i_word.address[15:13];
    assign a8     = i_word.address[8];
    assign upper  = i_word.data[1:0];
    assign sel5   = (i_word.data[4:0] == 5'd0) ? 7'd1 : {2'b00, i_word.data[4:0]};
    assign sel4   = (i_word.data[3:0] == 4'd0) ? 7'd1 : {3'b000, i_word.data[3:0]};
    assign sel7   = (i_word.data[6:0] == 7'd0) ? 7'd1 : i_word.data[6:0];

    always_comb begin
        o_state = i_state;
        rom_re  = 1'b0;
        ram_re  = 1'b0;
        en_wr   = 1'b0;
        ignored = 1'b0;
        unique case (i_type)
            cbm_pkg::MAPPER_MBC1: begin
                if (region == cbm_pkg::REGION_ENABLE) begin
                    o_state.enable_nibble = i_word.data[3:0];
                    en_wr = 1'b1;
                end else if (region == cbm_pkg::REGION_ROM) begin
                    o_state.rom_select = sel5;
                    o_state.mapped_rom = i_state.banking_mode ? sel5
                                       : sel5 + {i_state.upper_select, 5'd0};
                    rom_re = 1'b1;
                end else if (region == cbm_pkg::REGION_UPPER) begin
                    o_state.upper_select = upper;
                    if (i_state.banking_mode) begin
                        o_state.mapped_ram = upper;
                        ram_re = 1'b1;
                    end else begin
                        o_state.mapped_rom = i_state.rom_select + {upper, 5'd0};
                        rom_re = 1'b1;
                    end
                end else if (region == cbm_pkg::REGION_MODE) begin
                    o_state.banking_mode = i_word.data[0];
                    if (i_word.data[0]) begin
                        o_state.mapped_rom = i_state.rom_select;
                        rom_re = 1'b1;
                    end else begin
                        o_state.mapped_ram = '0;
                        ram_re = 1'b1;
                    end
                end else begin
                    ignored = 1'b1;
                end
            end
            cbm_pkg::MAPPER_MBC2: begin
                if (region == cbm_pkg::REGION_ENABLE && !a8) begin
                    o_state.enable_nibble = i_word.data[3:0];
                    en_wr = 1'b1;
                end else if (region == cbm_pkg::REGION_ROM && a8) begin
                    o_state.rom_select = sel4;
                    o_state.mapped_rom = sel4;
                    rom_re = 1'b1;
                end else begin
                    ignored = 1'b1;
                end
            end
            cbm_pkg::MAPPER_MBC3: begin
                if (region == cbm_pkg::REGION_ENABLE) begin
                    o_state.enable_nibble = i_word.data[3:0];
                    en_wr = 1'b1;
                end else if (region == cbm_pkg::REGION_ROM) begin
                    o_state.rom_select = sel7;
                    o_state.mapped_rom = sel7;
                    rom_re = 1'b1;
                end else if (region == cbm_pkg::REGION_UPPER) begin
                    o_state.upper_select = upper;
                    o_state.mapped_ram   = upper;
                    ram_re = 1'b1;
                end else if (region != cbm_pkg::REGION_MODE) begin
                    ignored = 1'b1;
                end
            end
            default: begin
                ignored = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_word.rom_bank       = o_state.mapped_rom;
        o_word.ram_bank       = o_state.mapped_ram;
        o_word.ram_enabled    = (o_state.enable_nibble == cbm_pkg::ENABLE_KEY);
        o_word.rom_remapped   = rom_re;
        o_word.ram_remapped   = ram_re;
        o_word.enable_written = en_wr;
        o_word.write_ignored  = ignored;
    end

endmodule

// File: hdl/cbm_out_reg.sv
// result register with valid and stall toward the consumer
module cbm_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  cbm_pkg::t_out_word i_word,
    input  logic               i_stall,
    output logic               o_ready,
    output logic               o_valid,
    output cbm_pkg::t_out_word o_word
);

    logic               r_valid;
    cbm_pkg::t_out_word r_word;

    assign o_ready = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_word <= i_word;
        end
    end

endmodule

// File: hdl/cartridge_bank_mapper_core.sv
// top level of the cartridge bank mapper
// Each accepted word is a CPU write (address, data) into cartridge space; one
// result word follows for every write, carrying the mapped ROM bank, RAM bank,
// RAM enable and which of them the write changed. A write passes an input
// register, then combinational decode against the bank registers, then the
// result register, so a word can be accepted every cycle while the output is
// not stalled. Writing the mapper type returns all bank registers to their
// reset values; do so only while idle.
module cartridge_bank_mapper_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  cbm_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output cbm_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_we,
    input  logic [cbm_pkg::TYPE_W-1:0]    i_cfg_data
);

    logic                          r_in_valid;
    cbm_pkg::t_in_word             r_in_word;
    logic [cbm_pkg::TYPE_W-1:0]    r_type;
    cbm_pkg::t_bank_state          r_state;
    cbm_pkg::t_bank_state          n_state;
    cbm_pkg::t_out_word            n_out;
    logic                          adv;
    logic                          fire;

    assign fire       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= cbm_pkg::MAPPER_NONE;
            r_state <= cbm_pkg::BANK_RESET;
        end else if (i_cfg_we) begin
            r_type  <= i_cfg_data;
            r_state <= cbm_pkg::BANK_RESET;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    cbm_decode u_decode (
        .i_type  (r_type),
        .i_word  (r_in_word),
        .i_state (r_state),
        .o_state (n_state),
        .o_word  (n_out)
    );

    cbm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_in_valid),
        .i_word  (n_out),
        .i_stall (i_out_stall),
        .o_ready (adv),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

`ifndef ASSERT_OFF
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_out_word.rom_remapped, o_out_word.ram_remapped,
                                  o_out_word.enable_written, o_out_word.write_ignored}))
        else $error("more than one write flag set");

    a_rom_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.rom_bank != '0))
        else $error("rom bank zero mapped");

    a_none_ignores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_type == cbm_pkg::MAPPER_NONE) |=> o_out_word.write_ignored)
        else $error("write decoded with no mapper");

    a_none_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_type == cbm_pkg::MAPPER_NONE) |-> (r_state == cbm_pkg::BANK_RESET))
        else $error("bank state changed with no mapper");
`endif

endmodule
